@@ rtl/core/ght_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared codes and control types of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_CHECK   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FREE = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_STALE   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } ght_stk_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ght_stk_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ght_free_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_free_stack
// LIFO of freed slot indexes in a synchronous memory with a depth counter.
// A pop registers the top entry, valid in the following cycle.
// ----------------------------------------------------------------------------
module ght_free_stack
  import ght_pkg::*;
#(
  parameter int MAX_SLOTS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ght_stk_req_t                 req,
  input  wire logic [$clog2(MAX_SLOTS)-1:0] push_idx,
  output logic      [$clog2(MAX_SLOTS)-1:0] top_idx,
  output ght_stk_stat_t                     stat
);

  localparam int IDXW = $clog2(MAX_SLOTS);

  logic [IDXW-1:0] stk_mem [MAX_SLOTS];
  logic [IDXW:0]   depth_r;
  logic [IDXW:0]   depth_nxt;
  logic [IDXW:0]   depth_m1;
  logic [IDXW-1:0] top_r;
  logic            do_push;
  logic            do_pop;

  assign stat.empty = (depth_r == '0);
  assign stat.full  = (depth_r == (IDXW + 1)'(MAX_SLOTS));
  assign do_push    = req.push && !stat.full;
  assign do_pop     = req.pop && !stat.empty;
  assign depth_m1   = depth_r - {{IDXW{1'b0}}, 1'b1};
  assign top_idx    = top_r;

  always_comb begin
    depth_nxt = depth_r;
    if (do_pop) begin
      depth_nxt = depth_m1;
    end else if (do_push) begin
      depth_nxt = depth_r + {{IDXW{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_mem[depth_r[IDXW-1:0]] <= push_idx;
    end
    if (do_pop) begin
      top_r <= stk_mem[depth_m1[IDXW-1:0]];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/generational_handle_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Slot table handing out handles (slot index plus one, with a generation)
// and keeping a reference count per slot. Slot state sits in one
// synchronous memory, freed slots in a LIFO memory.
//
//   channel | ports                                         | handshake
//   --------+-----------------------------------------------+-----------------
//   input   | in_command, in_handle_slot, in_handle_generation | start && !busy
//   result  | out_status, out_new_slot, out_new_generation,   | out_valid, 1 cyc
//           | out_references, out_slot_freed                  |
//   config  | cfg_data (slot_limit)                           | cfg_valid&&ready
//
// acquire, release, check and create of a never-used slot read the slot
// memory, then modify it and write it back. create from the free stack
// reads the stack first, then the slot. the result strobe is registered
// and follows in the cycle after the write-back; the receiver cannot
// stall. never-used slots are tracked by a fill count, so reset needs
// no clearing pass.
// ----------------------------------------------------------------------------
module generational_handle_table_core
  import ght_pkg::*;
#(
  parameter int MAX_SLOTS       = 256,
  parameter int GENERATION_BITS = 16,
  parameter int REFERENCE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [8:0]  in_handle_slot,
  input  wire logic [15:0] in_handle_generation,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [8:0]       out_new_slot,
  output logic [15:0]      out_new_generation,
  output logic [15:0]      out_references,
  output logic             out_slot_freed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);

  localparam int IDXW = $clog2(MAX_SLOTS);
  localparam int CW   = (IDXW + 1 > 9) ? IDXW + 1 : 9;
  localparam int GB   = GENERATION_BITS;
  localparam int RB   = REFERENCE_BITS;
  localparam int GCW  = (GB > 16) ? GB : 16;
  localparam int SW   = 1 + GB + RB;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [1:0]      cmd_r;
  logic [8:0]      handle_r;
  logic [15:0]     hgen_r;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic            fill_mode_r, fill_mode_nxt;
  logic            none_r, none_nxt;
  logic [8:0]      slot_limit_r;
  logic [IDXW:0]   fill_r, fill_nxt;

  logic [SW-1:0]   slot_mem [MAX_SLOTS];
  logic [SW-1:0]   slot_rd_r;
  logic [IDXW-1:0] slot_rd_addr;
  logic            slot_rd_en;
  logic            slot_we;
  logic [SW-1:0]   slot_wr_data;

  ght_stk_req_t    stk_req;
  ght_stk_stat_t   stk_stat;
  logic [IDXW-1:0] stk_top;
  logic            stk_pop;
  logic            stk_push;

  logic            accept;
  logic [8:0]      hsub;
  logic [CW-1:0]   eff_lim;
  logic            fill_avail;

  logic            rd_vld;
  logic            rd_use;
  logic [GB-1:0]   rd_gen;
  logic [RB-1:0]   rd_ref;
  logic [GB-1:0]   gen_inc;
  logic [GB-1:0]   gen_new;
  logic [RB-1:0]   ref_new;
  logic [IDXW:0]   idx_p1;
  logic            range_err;
  logic            stale_err;

  logic [2:0]      res_status;
  logic [8:0]      res_new_slot;
  logic [15:0]     res_new_gen;
  logic [15:0]     res_refs;
  logic            res_freed;

  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [8:0]      out_new_slot_r;
  logic [15:0]     out_new_gen_r;
  logic [15:0]     out_refs_r;
  logic            out_freed_r;

  ght_free_stack #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (stk_req),
    .push_idx(idx_r),
    .top_idx (stk_top),
    .stat    (stk_stat)
  );

  assign stk_req    = '{push: stk_push, pop: stk_pop};
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !start;
  assign hsub       = in_handle_slot - 9'd1;
  assign eff_lim    = (CW'(slot_limit_r) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                           : CW'(slot_limit_r);
  assign fill_avail = (CW'(fill_r) < eff_lim);

  // input transaction and sequencing
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fill_mode_nxt = fill_mode_r;
    none_nxt      = none_r;
    stk_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          fill_mode_nxt = 1'b0;
          none_nxt      = 1'b0;
          state_nxt     = S_EXEC;
          idx_nxt       = IDXW'(hsub);
          if (in_command == CMD_CREATE) begin
            if (!stk_stat.empty) begin
              stk_pop   = 1'b1;
              state_nxt = S_POP;
            end else if (fill_avail) begin
              fill_mode_nxt = 1'b1;
              idx_nxt       = fill_r[IDXW-1:0];
            end else begin
              none_nxt = 1'b1;
            end
          end
        end
      end
      S_POP: begin
        idx_nxt   = stk_top;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign slot_rd_en   = accept || (state_r == S_POP);
  assign slot_rd_addr = (state_r == S_POP) ? stk_top : IDXW'(hsub);

  // read data of slots at or above the fill count was never written
  assign rd_vld  = ({1'b0, idx_r} < fill_r);
  assign rd_use  = rd_vld && slot_rd_r[SW-1];
  assign rd_gen  = rd_vld ? slot_rd_r[GB+RB-1:RB] : '0;
  assign rd_ref  = rd_vld ? slot_rd_r[RB-1:0] : '0;
  assign gen_inc = rd_gen + {{(GB-1){1'b0}}, 1'b1};
  assign idx_p1  = {1'b0, idx_r} + {{IDXW{1'b0}}, 1'b1};

  assign range_err = (handle_r == 9'd0) || (CW'(handle_r) > eff_lim);
  assign stale_err = (GCW'(rd_gen) != GCW'(hgen_r));

  // slot modify and write-back
  always_comb begin
    res_status   = ST_OK;
    res_new_slot = 9'd0;
    res_new_gen  = 16'd0;
    res_refs     = 16'd0;
    res_freed    = 1'b0;
    slot_we      = 1'b0;
    stk_push     = 1'b0;
    fill_nxt     = fill_r;
    gen_new      = rd_gen;
    ref_new      = rd_ref;
    slot_wr_data = {rd_use, rd_gen, rd_ref};
    if (state_r == S_EXEC) begin
      if (cmd_r == CMD_CREATE) begin
        if (none_r) begin
          res_status = ST_NO_FREE;
        end else begin
          if (fill_mode_r) begin
            gen_new  = {{(GB-1){1'b0}}, 1'b1};
            fill_nxt = idx_p1;
          end else if (gen_inc == '0) begin
            gen_new = {{(GB-1){1'b0}}, 1'b1};
          end else begin
            gen_new = gen_inc;
          end
          ref_new      = {{(RB-1){1'b0}}, 1'b1};
          slot_we      = 1'b1;
          slot_wr_data = {1'b1, gen_new, ref_new};
          res_new_slot = 9'(idx_p1);
          res_new_gen  = 16'(gen_new);
          res_refs     = 16'd1;
        end
      end else if (range_err) begin
        res_status = ST_RANGE;
      end else if (stale_err) begin
        res_status = ST_STALE;
      end else if (!rd_use) begin
        res_status = ST_EMPTY;
      end else begin
        case (cmd_r)
          CMD_ACQUIRE: begin
            if (rd_ref != {RB{1'b1}}) begin
              ref_new = rd_ref + {{(RB-1){1'b0}}, 1'b1};
            end
            slot_we      = 1'b1;
            slot_wr_data = {1'b1, rd_gen, ref_new};
          end
          CMD_RELEASE: begin
            if (rd_ref != '0) begin
              ref_new = rd_ref - {{(RB-1){1'b0}}, 1'b1};
            end
            slot_we = 1'b1;
            if (ref_new == '0) begin
              stk_push     = 1'b1;
              res_freed    = 1'b1;
              slot_wr_data = {1'b0, rd_gen, ref_new};
            end else begin
              slot_wr_data = {1'b1, rd_gen, ref_new};
            end
          end
          default: begin
            ref_new = rd_ref;
          end
        endcase
        res_refs = 16'(ref_new);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      slot_limit_r <= 9'd256;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= (state_r == S_EXEC);
      if (cfg_valid && cfg_ready) begin
        slot_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    fill_mode_r <= fill_mode_nxt;
    none_r      <= none_nxt;
    if (accept) begin
      cmd_r    <= in_command;
      handle_r <= in_handle_slot;
      hgen_r   <= in_handle_generation;
    end
    if (state_r == S_EXEC) begin
      out_status_r   <= res_status;
      out_new_slot_r <= res_new_slot;
      out_new_gen_r  <= res_new_gen;
      out_refs_r     <= res_refs;
      out_freed_r    <= res_freed;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[idx_r] <= slot_wr_data;
    end
    if (slot_rd_en) begin
      slot_rd_r <= slot_mem[slot_rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_new_slot       = out_new_slot_r;
  assign out_new_generation = out_new_gen_r;
  assign out_references     = out_refs_r;
  assign out_slot_freed     = out_freed_r;

endmodule
`default_nettype wire

@@ rtl/core/ght_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks of the handle table result transactions.
// ----------------------------------------------------------------------------
module ght_checker
  import ght_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [8:0]  out_new_slot,
  input wire logic [15:0] out_new_generation,
  input wire logic [15:0] out_references,
  input wire logic        out_slot_freed
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_new_slot == 9'd0 && out_new_generation == 16'd0 &&
       out_references == 16'd0 && !out_slot_freed))
    else $error("failed transaction carries nonzero payload");

  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_slot_freed) |-> (out_status == ST_OK && out_references == 16'd0))
    else $error("freed slot with bad status or count");

  a_create_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_new_slot != 9'd0)) |->
      (out_references == 16'd1 && out_new_generation != 16'd0))
    else $error("created handle with bad count or generation");

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (.*);
`default_nettype wire
